[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication with the consequent checked on the next clock.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ibr_pkg.sv]
package ibr_pkg;

  localparam int unsigned MaxFactorDef = 8;
  localparam int unsigned MaxWidthDef  = 4096;
  localparam int unsigned PixelBitsDef = 16;

  localparam int unsigned PosBits = 15;
  localparam int unsigned AccBits = 22;

  // Mode codes
  localparam logic [2:0] MODE_AVG = 3'd0;
  localparam logic [2:0] MODE_MED = 3'd1;
  localparam logic [2:0] MODE_MAX = 3'd2;
  localparam logic [2:0] MODE_MIN = 3'd3;
  localparam logic [2:0] MODE_UP  = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_FACTOR = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // Request from sequencer to divider
  typedef struct packed {
    logic        start;
    logic [21:0] dividend;
    logic [6:0]  divisor;
  } div_req_t;

endpackage

[rtl/ibr_divider.sv]
// Restoring divider, one quotient bit per cycle.
module ibr_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  ibr_pkg::div_req_t  req,
  output logic               busy,
  output logic [21:0]        quotient
);
  import ibr_pkg::*;

  logic [21:0] q_r, q_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [6:0]  dsr_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r;
  logic [7:0]  trial;

  assign trial = {rem_r, q_r[21]} - {1'b0, dsr_r};

  // Shift and subtract step
  always_comb begin
    q_nxt   = {q_r[20:0], 1'b0};
    rem_nxt = {rem_r[5:0], q_r[21]};
    cnt_nxt = cnt_r - 5'd1;
    if (!trial[7]) begin
      rem_nxt  = trial[6:0];
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd22;
    end else if (busy_r) begin
      cnt_r <= cnt_nxt;
      if (cnt_r == 5'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_div_done, busy_r && cnt_r == 5'd1 && !req.start, !busy_r)
  `ASSERT_IMPL(a_div_cnt, busy_r, cnt_r != 5'd0)
  `ASSERT_NEXT(a_div_start, req.start, busy_r && cnt_r == 5'd22)
endmodule

[rtl/integer_block_resampler.sv]
// Integer block resampler: takes one pixel plane in raster order and
// downsamples by the factor (average, median, maximum, minimum of each whole
// factor x factor block, emitted at the block's coordinate) or upsamples by
// replicating each pixel factor*factor times. Other modes, and downsampling
// by a factor not below the width or height, pass pixels through. A pixel
// is accepted in S_IDLE and applied in S_UPD; an average waits in S_DIV for
// the bit-serial divider. A median reads the f*f window from the row store
// one entry per cycle, then ranks entries against the window one pair at a
// time, with registered reads, until it finds the median. An upsample sends
// one copy per cycle unless the receiver stalls; every result waits as long
// as the receiver stalls. The block is not ready while a pixel is at work,
// and a pending register write holds off the pixel input. Any configuration
// write restarts the plane at column 0, row 0. The stores hold no reset.
module integer_block_resampler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ibr_pkg::PixelBitsDef-1:0] in_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ibr_pkg::PixelBitsDef-1:0] out_value,
  output logic [14:0]                     out_x,
  output logic [14:0]                     out_y,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [12:0]                     cfg_data
);
  import ibr_pkg::*;

  localparam int unsigned MAX_FACTOR = MaxFactorDef;
  localparam int unsigned MAX_WIDTH  = MaxWidthDef;
  localparam int unsigned PIXEL_BITS = PixelBitsDef;

  localparam int unsigned WB  = $clog2(MAX_WIDTH);
  localparam int unsigned FB  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int unsigned NB  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int unsigned MB  = FB + WB;
  localparam int unsigned MAXF_W = $clog2(MAX_FACTOR + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_UPD   = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_MLOAD = 8'b0000_1000,
    S_MRANK = 8'b0001_0000,
    S_UP    = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_MWAIT = 8'b1000_0000
  } state_t;

  state_t state_r;

  logic [2:0]  mode_r;
  logic [3:0]  factor_r;
  logic [12:0] width_r, height_r;
  logic [WB-1:0] col_r, row_r;

  // Clamped settings
  logic [MAXF_W-1:0] f;
  logic [13:0] w, h;
  always_comb begin
    if (factor_r == 4'd0) f = MAXF_W'(1);
    else if (32'(factor_r) > MAX_FACTOR) f = MAXF_W'(MAX_FACTOR);
    else f = MAXF_W'(factor_r);
    w = (width_r == 13'd0) ? 14'd1 :
        (32'(width_r) > MAX_WIDTH) ? 14'(MAX_WIDTH) : {1'b0, width_r};
    h = (height_r == 13'd0) ? 14'd1 :
        (32'(height_r) > MAX_WIDTH) ? 14'(MAX_WIDTH) : {1'b0, height_r};
  end

  // Position within the block, tracked incrementally
  logic [FB:0] ix_r, iy_r;
  logic [WB-1:0] bx_r, by_r, bx0_r;

  logic [PIXEL_BITS-1:0] px_r;
  logic [AccBits-1:0] acc_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] med_mem [MAX_FACTOR * MAX_WIDTH];
  logic [AccBits-1:0] acc_rd_r;
  logic [PIXEL_BITS-1:0] med_rd_r;
  logic [AccBits-1:0] acc_nxt;

  logic [PIXEL_BITS-1:0] win_r [MAX_FACTOR * MAX_FACTOR];
  logic [NB-1:0] n_r, a_r, b_r, cnt_lt_r, cnt_le_r;
  logic [NB-1:0] nn, mid;
  logic [FB:0] li_r, lj_r, li_nxt, lj_nxt;
  logic [PIXEL_BITS-1:0] wa_r, wb_r;
  logic cmp_v_r, blast_r;
  logic [PIXEL_BITS-1:0] res_r;
  logic [14:0] ox_r, oy_r;
  logic last_r;
  logic [FB:0] ui_r, uj_r;

  div_req_t dreq;
  logic dbusy;
  logic [21:0] dquot;
  ibr_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quotient(dquot));

  assign nn  = NB'(f) * NB'(f);
  assign mid = nn >> 1;

  logic passthru, in_blk, blk_end, is_first;
  assign passthru = (mode_r > MODE_UP) || (14'(f) >= w) || (14'(f) >= h);
  // bx < w / f is the same as (bx + 1) * f <= w
  assign in_blk   = ((32'(bx_r) + 32'd1) * 32'(f) <= 32'(w)) &&
                    ((32'(by_r) + 32'd1) * 32'(f) <= 32'(h));
  assign is_first = (ix_r == '0) && (iy_r == '0);
  assign blk_end  = (ix_r == (FB+1)'(f - 1'b1)) && (iy_r == (FB+1)'(f - 1'b1));

  logic in_xfer, out_xfer, cfg_xfer;
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT) || (state_r == S_UP);
  assign out_xfer  = out_valid && !out_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // Window walk over the row store: column inside the block, then row
  always_comb begin
    if (li_r == (FB+1)'(f - 1'b1)) begin
      li_nxt = '0;
      lj_nxt = lj_r + 1'b1;
    end else begin
      li_nxt = li_r + 1'b1;
      lj_nxt = lj_r;
    end
  end

  logic [MB-1:0] med_waddr, med_raddr;
  assign med_waddr = MB'(32'(iy_r) * MAX_WIDTH + 32'(col_r));
  assign med_raddr = MB'(32'(lj_r) * MAX_WIDTH + 32'(bx0_r) + 32'(li_r));

  // Store reads and writes
  always_ff @(posedge clk) begin
    acc_rd_r <= acc_mem[bx_r];
    med_rd_r <= med_mem[med_raddr];
    if (state_r == S_UPD && !passthru && mode_r != MODE_UP && in_blk) begin
      if (mode_r == MODE_MED) med_mem[med_waddr] <= px_r;
      else acc_mem[bx_r] <= acc_nxt;
    end
  end

  always_comb begin
    case (mode_r)
      MODE_AVG: acc_nxt = acc_rd_r + AccBits'(px_r);
      MODE_MAX: acc_nxt = (AccBits'(px_r) > acc_rd_r) ? AccBits'(px_r) : acc_rd_r;
      default:  acc_nxt = (AccBits'(px_r) < acc_rd_r) ? AccBits'(px_r) : acc_rd_r;
    endcase
    if (is_first) acc_nxt = AccBits'(px_r);
  end

  // Window reads for the rank search
  always_ff @(posedge clk) begin
    wa_r <= win_r[a_r[NB-2:0]];
    wb_r <= win_r[b_r[NB-2:0]];
  end

  always_comb begin
    dreq = '0;
    if (state_r == S_UPD && mode_r == MODE_AVG && !passthru && in_blk && blk_end) begin
      dreq.start    = 1'b1;
      dreq.dividend = acc_nxt;
      dreq.divisor  = 7'(nn);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r <= MODE_AVG; factor_r <= 4'd2;
      width_r <= 13'd4096; height_r <= 13'd4096;
      col_r <= '0; row_r <= '0; ix_r <= '0; iy_r <= '0; bx_r <= '0; by_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cfg_xfer) begin
            unique case (cfg_index)
              REG_MODE:   mode_r   <= cfg_data[2:0];
              REG_FACTOR: factor_r <= cfg_data[3:0];
              REG_WIDTH:  width_r  <= cfg_data;
              REG_HEIGHT: height_r <= cfg_data;
              default: ;
            endcase
            col_r <= '0; row_r <= '0; ix_r <= '0; iy_r <= '0; bx_r <= '0; by_r <= '0;
          end else if (in_xfer) begin
            px_r    <= in_pixel;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          ui_r <= '0; uj_r <= '0;
          li_r <= '0; lj_r <= '0; n_r <= '0;
          bx0_r <= WB'(32'(bx_r) * 32'(f));
          if (mode_r == MODE_UP) begin
            res_r <= px_r;
            ox_r <= 15'(32'(col_r) * 32'(f)); oy_r <= 15'(32'(row_r) * 32'(f));
            last_r <= (f == MAXF_W'(1));
            state_r <= S_UP;
          end else if (passthru) begin
            res_r <= px_r;
            ox_r <= 15'(col_r); oy_r <= 15'(row_r); last_r <= 1'b1;
            state_r <= S_OUT;
          end else if (in_blk && blk_end) begin
            ox_r <= 15'(bx_r); oy_r <= 15'(by_r); last_r <= 1'b1;
            res_r <= PIXEL_BITS'(acc_nxt);
            unique case (mode_r)
              MODE_AVG: state_r <= S_DIV;
              MODE_MED: state_r <= S_MWAIT;
              default:  state_r <= S_OUT;
            endcase
          end else begin
            state_r <= S_IDLE;
          end
          // advance position
          if (32'(col_r) + 1 >= 32'(w)) begin
            col_r <= '0; ix_r <= '0; bx_r <= '0;
            if (32'(row_r) + 1 >= 32'(h)) begin
              row_r <= '0; iy_r <= '0; by_r <= '0;
            end else begin
              row_r <= row_r + 1'b1;
              if (iy_r == (FB+1)'(f - 1'b1)) begin iy_r <= '0; by_r <= by_r + 1'b1; end
              else iy_r <= iy_r + 1'b1;
            end
          end else begin
            col_r <= col_r + 1'b1;
            if (ix_r == (FB+1)'(f - 1'b1)) begin ix_r <= '0; bx_r <= bx_r + 1'b1; end
            else ix_r <= ix_r + 1'b1;
          end
        end
        S_DIV: begin
          if (!dbusy && !dreq.start) begin
            res_r <= PIXEL_BITS'(dquot);
            state_r <= S_OUT;
          end
        end
        S_MWAIT: begin
          li_r <= li_nxt; lj_r <= lj_nxt;
          state_r <= S_MLOAD;
        end
        S_MLOAD: begin
          win_r[n_r[NB-2:0]] <= med_rd_r;
          n_r <= n_r + 1'b1;
          li_r <= li_nxt; lj_r <= lj_nxt;
          if (n_r + 1'b1 == nn) begin
            a_r <= '0; b_r <= '0; cnt_lt_r <= '0; cnt_le_r <= '0;
            cmp_v_r <= 1'b0;
            state_r <= S_MRANK;
          end
        end
        S_MRANK: begin
          // issue the next pair; the registered window data arrives in the next cycle
          if (b_r + 1'b1 == nn) begin
            a_r <= a_r + 1'b1; b_r <= '0;
          end else begin
            b_r <= b_r + 1'b1;
          end
          cmp_v_r <= 1'b1;
          blast_r <= (b_r + 1'b1 == nn);
          // rank of the candidate: count smaller and not larger entries
          if (cmp_v_r) begin
            if (blast_r) begin
              if ((cnt_lt_r + NB'(wb_r < wa_r)) <= mid &&
                  (cnt_le_r + NB'(wb_r <= wa_r)) > mid) begin
                res_r <= wa_r;
                state_r <= S_OUT;
              end
              cnt_lt_r <= '0; cnt_le_r <= '0;
            end else begin
              cnt_lt_r <= cnt_lt_r + NB'(wb_r < wa_r);
              cnt_le_r <= cnt_le_r + NB'(wb_r <= wa_r);
            end
          end
        end
        S_UP: begin
          if (out_xfer) begin
            if (last_r) state_r <= S_IDLE;
            else begin
              if (ui_r == (FB+1)'(f - 1'b1)) begin
                ui_r <= '0; uj_r <= uj_r + 1'b1;
                ox_r <= ox_r - 15'(f - 1'b1); oy_r <= oy_r + 1'b1;
                last_r <= (uj_r + 1'b1 == (FB+1)'(f - 1'b1)) && (f == MAXF_W'(1));
              end else begin
                ui_r <= ui_r + 1'b1; ox_r <= ox_r + 1'b1;
                last_r <= (uj_r == (FB+1)'(f - 1'b1)) && (ui_r + 1'b1 == (FB+1)'(f - 1'b1));
              end
            end
          end
        end
        S_OUT: if (out_xfer) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_value = res_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_last  = last_r;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_in_busy, state_r != S_IDLE, in_stall)
  `ASSERT_IMPL(a_cfg_idle, cfg_xfer, !in_xfer)
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value))
  `ASSERT_IMPL(a_onehot, 1'b1, $onehot(state_r))
endmodule

[dv/resampler_checker.sv]
module resampler_checker
  import ibr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_pixel,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_value,
  input  logic [14:0] out_x,
  input  logic [14:0] out_y,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [15:0] value;
    logic [14:0] x;
    logic [14:0] y;
    logic        last;
  } pix_out_t;

  // Shadow registers and position
  logic [2:0]  cur_mode;
  logic [3:0]  cur_factor;
  logic [12:0] cur_width;
  logic [12:0] cur_height;
  int unsigned col_pos;
  int unsigned row_pos;

  // Shadow stores
  logic [21:0] blk_acc [MaxWidthDef];
  logic [15:0] row_store [MaxFactorDef*MaxWidthDef];

  pix_out_t resampled_q [$];

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Median of the f x f window starting at column c0
  function automatic logic [15:0] window_median(int unsigned c0, int unsigned f);
    logic [15:0] win [64];
    logic [15:0] t;
    int unsigned n;
    int b;
    n = 0;
    for (int j = 0; j < f; j++)
      for (int i = 0; i < f; i++) begin
        win[n] = row_store[j*MaxWidthDef + c0 + i];
        n++;
      end
    for (int a = 1; a < n; a++) begin
      t = win[a];
      b = a;
      while (b > 0 && win[b-1] > t) begin
        win[b] = win[b-1];
        b--;
      end
      win[b] = t;
    end
    return win[n/2];
  endfunction

  // Work out the results of one accepted pixel
  task automatic resample_pixel(input logic [15:0] px);
    int unsigned f, w, h, col, row, bx, by, i, j;
    logic [21:0] v;
    pix_out_t r;
    f = clip(cur_factor, 1, MaxFactorDef);
    w = clip(cur_width, 1, MaxWidthDef);
    h = clip(cur_height, 1, MaxWidthDef);
    col = col_pos % w;
    row = row_pos % h;
    if (cur_mode == MODE_UP) begin
      for (int jj = 0; jj < f; jj++)
        for (int ii = 0; ii < f; ii++) begin
          r.value = px;
          r.x = 15'(col*f + ii);
          r.y = 15'(row*f + jj);
          r.last = (jj == f-1) && (ii == f-1);
          resampled_q.push_back(r);
        end
    end else if (cur_mode > MODE_UP || f >= w || f >= h) begin
      r = '{px, 15'(col), 15'(row), 1'b1};
      resampled_q.push_back(r);
    end else begin
      bx = col / f;
      by = row / f;
      i = col % f;
      j = row % f;
      if (bx < w/f && by < h/f) begin
        if (cur_mode == MODE_MED) row_store[j*MaxWidthDef + col] = px;
        else if (i == 0 && j == 0) blk_acc[bx] = 22'(px);
        else if (cur_mode == MODE_AVG) blk_acc[bx] = blk_acc[bx] + 22'(px);
        else if (cur_mode == MODE_MAX) begin
          if (22'(px) > blk_acc[bx]) blk_acc[bx] = 22'(px);
        end else if (22'(px) < blk_acc[bx]) blk_acc[bx] = 22'(px);
        if (i == f-1 && j == f-1) begin
          if (cur_mode == MODE_MED) v = 22'(window_median(bx*f, f));
          else if (cur_mode == MODE_AVG) v = blk_acc[bx] / 22'(f*f);
          else v = blk_acc[bx];
          r = '{v[15:0], 15'(bx), 15'(by), 1'b1};
          resampled_q.push_back(r);
        end
      end
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    col_pos = col;
    row_pos = row;
  endtask

  always @(posedge clk) begin
    pix_out_t e;
    if (!rst_n) begin
      cur_mode = MODE_AVG;
      cur_factor = 4'd2;
      cur_width = 13'd4096;
      cur_height = 13'd4096;
      col_pos = 0;
      row_pos = 0;
      fails = 0;
      resampled_q.delete();
    end else begin
      // Result transfer
      if (out_valid && !out_stall) begin
        if (resampled_q.size() == 0) begin
          $display("%0t: unexpected result value=%h x=%0d y=%0d last=%b",
                   $time, out_value, out_x, out_y, out_last);
          fails++;
        end else begin
          e = resampled_q.pop_front();
          if (e.value !== out_value) begin
            $display("%0t: value expected %h got %h", $time, e.value, out_value);
            fails++;
          end
          if (e.x !== out_x) begin
            $display("%0t: x expected %0d got %0d", $time, e.x, out_x);
            fails++;
          end
          if (e.y !== out_y) begin
            $display("%0t: y expected %0d got %0d", $time, e.y, out_y);
            fails++;
          end
          if (e.last !== out_last) begin
            $display("%0t: last expected %b got %b", $time, e.last, out_last);
            fails++;
          end
        end
      end
      // Register write restarts the plane
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:   cur_mode = cfg_data[2:0];
          REG_FACTOR: cur_factor = cfg_data[3:0];
          REG_WIDTH:  cur_width = cfg_data;
          REG_HEIGHT: cur_height = cfg_data;
        endcase
        col_pos = 0;
        row_pos = 0;
      end
      // Pixel transfer
      if (in_valid && !in_stall) resample_pixel(in_pixel);
    end
    pending = resampled_q.size();
  end

  final begin
  end

endmodule

[dv/integer_block_resampler_test.sv]
module integer_block_resampler_test;
  import ibr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_pixel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_value;
  logic [14:0] out_x;
  logic [14:0] out_y;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_MODE;
  logic [12:0] cfg_data = '0;

  int fails;
  int pending;
  int items = 0;
  int cycles = 0;
  bit hold_go = 0;

  integer_block_resampler dut (.*);

  resampler_checker chk (.*);

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("integer_block_resampler_test NOT OK");
      $finish;
    end
  end

  // Receiver stall: random stretches, plus one long hold-off on request
  always @(negedge clk) begin
    static int hold_left = 0;
    static int stretch = 0;
    static int style = 0;
    if (hold_go) begin
      hold_go = 0;
      hold_left = 400;
    end
    if (stretch == 0) begin
      stretch = $urandom_range(5, 60);
      style = $urandom_range(0, 2);
    end
    stretch--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (style == 0) out_stall <= 1'b0;
    else if (style == 1) out_stall <= ($urandom_range(0, 9) < 3);
    else out_stall <= ($urandom_range(0, 9) < 7);
  end

  // One pixel transfer; valid stays high for the next one
  task automatic send_pixel(input logic [15:0] v);
    in_valid <= 1'b1;
    in_pixel <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items++;
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // One register transfer; the caller lowers valid
  task automatic write_reg(input logic [1:0] idx, input logic [12:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Wait until idle, then load all four registers
  task automatic set_plane(input logic [2:0] m, input logic [12:0] f,
                           input logic [12:0] w, input logic [12:0] h);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(negedge clk);
    write_reg(REG_MODE, {10'd0, m});
    write_reg(REG_FACTOR, f);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stream n pixels in bursts; extreme values when edgy is set
  task automatic stream(input int n, input bit edgy);
    int burst;
    logic [15:0] v;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 10);
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
      end
      burst--;
      v = 16'($urandom_range(0, 65535));
      if (edgy) v = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      else if ($urandom_range(0, 7) == 0) v = 16'hFFFF;
      send_pixel(v);
    end
  endtask

  initial begin
    logic [2:0]  m;
    logic [12:0] f, w, h;
    int n;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: defaults, every mode, pass-through and clamped registers
    stream(2, 1);
    set_plane(MODE_AVG, 2, 4, 2);
    stream(8, 1);
    set_plane(MODE_MED, 2, 4, 2);
    stream(8, 0);
    set_plane(MODE_MAX, 2, 2, 2);
    stream(4, 0);
    set_plane(MODE_MIN, 2, 3, 2);
    stream(6, 0);
    set_plane(MODE_UP, 8, 2, 2);
    hold_go = 1;
    stream(3, 0);
    set_plane(3'd7, 0, 0, 0);
    stream(2, 0);
    set_plane(MODE_AVG, 15, 8191, 1);
    stream(2, 0);
    set_plane(MODE_MED, 2, 4096, 4096);
    stream(2, 0);

    // Largest factor with a whole block, and an odd median window
    set_plane(MODE_AVG, 8, 9, 9);
    stream(71, 0);
    set_plane(MODE_MED, 3, 4, 4);
    stream(11, 0);

    // Random planes
    while (items < 130) begin
      n = $urandom_range(0, 9);
      m = (n < 8) ? 3'(n % 5) : 3'($urandom_range(5, 7));
      f = 13'($urandom_range(1, 4));
      if ($urandom_range(0, 9) == 0) f = 13'($urandom_range(0, 15));
      w = 13'($urandom_range(1, 9));
      h = 13'($urandom_range(1, 6));
      n = int'(w) * int'(h) * $urandom_range(1, 2);
      if (n > 30) n = 30;
      if (m == MODE_UP && f > 4) n = 3;
      set_plane(m, f, w, h);
      stream(n, 0);
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0) $display("integer_block_resampler_test OK");
    else $display("integer_block_resampler_test NOT OK");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ibr_pkg.sv
rtl/ibr_divider.sv
rtl/integer_block_resampler.sv
dv/resampler_checker.sv
dv/integer_block_resampler_test.sv
